[src/interrupt_aggregator_panel_glue_macros.svh]
// Assertion helpers for the interrupt aggregator / panel glue.
// Each checks on the rising edge of clk and is held off while rst is high.
`ifndef INTERRUPT_AGGREGATOR_PANEL_GLUE_MACROS_SVH
`define INTERRUPT_AGGREGATOR_PANEL_GLUE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define IAPG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IAPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define IAPG_ASSERT_IMPL(label, ante, cons, msg)
`define IAPG_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[src/iapg_pkg.sv]
`timescale 1ns / 1ps

package iapg_pkg;

  typedef enum logic [2:0] {
    OP_BUS_READ  = 3'd0,
    OP_BUS_WRITE = 3'd1,
    OP_PCM       = 3'd2,
    OP_DIAL      = 3'd3,
    OP_PORT      = 3'd4
  } opcode_t;

  // bus register offsets
  localparam logic [1:0] REG_STROBE = 2'd1;
  localparam logic [1:0] REG_IRQ    = 2'd2;

  // interrupt source numbers
  localparam logic [3:0] SRC_NONE      = 4'd0;
  localparam logic [3:0] SRC_DIAL_DOWN = 4'd3;
  localparam logic [3:0] SRC_DIAL_UP   = 4'd4;
  localparam logic [3:0] SRC_PCM       = 4'd5;

  // strobe bit that masks switch row 0; rows 1 and 2 follow
  localparam int ROW_STROBE_BASE = 2;

  localparam logic [7:0] PORT_IDLE = 8'hff;

  typedef struct packed {
    logic [2:0] opcode;
    logic [1:0] reg_offset;
    logic [7:0] write_data;
    logic       pcm_level;
    logic [7:0] dial_position;
    logic [7:0] row_zero_keys;
    logic [7:0] row_one_keys;
    logic [7:0] row_two_keys;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_asserted;
    logic [7:0] panel_strobe;
  } result_t;

  // current interrupt and strobe state, seen by the top level
  typedef struct packed {
    logic       irq;
    logic [7:0] strobe;
  } status_t;

  // Latch src when its enable bit (src - 1) is set and nothing is pending.
  function automatic logic [3:0] raise_src(logic [3:0] src, logic [7:0] mask,
                                           logic [3:0] pend);
    logic [3:0] idx_full;
    logic [2:0] idx;
    idx_full = src - 4'd1;
    idx      = idx_full[2:0];
    return (mask[idx] && (pend == SRC_NONE)) ? src : pend;
  endfunction

endpackage

[src/iapg_core.sv]
`timescale 1ns / 1ps

module iapg_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  iapg_pkg::item_t   item,
  output iapg_pkg::result_t res,
  output iapg_pkg::status_t status
);

  logic [7:0] enable_mask,    enable_mask_next;
  logic [3:0] pending_source, pending_source_next;
  logic [7:0] strobe_reg,     strobe_reg_next;
  logic       pcm_prev_level, pcm_prev_level_next;
  logic [7:0] dial_last,      dial_last_next;
  logic [7:0] delta;
  logic [7:0] rdata;

  assign delta = item.dial_position - dial_last;

  always_comb begin
    enable_mask_next    = enable_mask;
    pending_source_next = pending_source;
    strobe_reg_next     = strobe_reg;
    pcm_prev_level_next = pcm_prev_level;
    dial_last_next      = dial_last;
    rdata               = 8'd0;
    case (item.opcode)
      iapg_pkg::OP_BUS_READ: begin
        if (item.reg_offset == iapg_pkg::REG_IRQ) begin
          rdata               = {4'd0, pending_source};
          pending_source_next = iapg_pkg::SRC_NONE;
        end
      end
      iapg_pkg::OP_BUS_WRITE: begin
        if (item.reg_offset == iapg_pkg::REG_STROBE) begin
          strobe_reg_next = item.write_data;
        end else if (item.reg_offset == iapg_pkg::REG_IRQ) begin
          enable_mask_next    = item.write_data;
          pending_source_next = iapg_pkg::SRC_NONE;
        end
      end
      iapg_pkg::OP_PCM: begin
        if (item.pcm_level && !pcm_prev_level) begin
          pending_source_next = iapg_pkg::raise_src(iapg_pkg::SRC_PCM, enable_mask,
                                                    pending_source);
        end
        pcm_prev_level_next = item.pcm_level;
      end
      iapg_pkg::OP_DIAL: begin
        dial_last_next = item.dial_position;
        // 0x80 counts as a negative step
        if (delta != 8'd0) begin
          if (!delta[7]) begin
            pending_source_next = iapg_pkg::raise_src(iapg_pkg::SRC_DIAL_UP, enable_mask,
                                                      pending_source);
          end else begin
            pending_source_next = iapg_pkg::raise_src(iapg_pkg::SRC_DIAL_DOWN, enable_mask,
                                                      pending_source);
          end
        end
      end
      iapg_pkg::OP_PORT: begin
        rdata = iapg_pkg::PORT_IDLE;
        if (!strobe_reg[iapg_pkg::ROW_STROBE_BASE]) begin
          rdata = rdata & item.row_zero_keys;
        end
        if (!strobe_reg[iapg_pkg::ROW_STROBE_BASE + 1]) begin
          rdata = rdata & item.row_one_keys;
        end
        if (!strobe_reg[iapg_pkg::ROW_STROBE_BASE + 2]) begin
          rdata = rdata & item.row_two_keys;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask    <= 8'd0;
      pending_source <= iapg_pkg::SRC_NONE;
      strobe_reg     <= 8'd0;
      pcm_prev_level <= 1'b0;
      dial_last      <= 8'd0;
    end else if (fire) begin
      enable_mask    <= enable_mask_next;
      pending_source <= pending_source_next;
      strobe_reg     <= strobe_reg_next;
      pcm_prev_level <= pcm_prev_level_next;
      dial_last      <= dial_last_next;
    end
  end

  assign res.read_data    = rdata;
  assign res.irq_asserted = (pending_source_next != iapg_pkg::SRC_NONE);
  assign res.panel_strobe = strobe_reg_next;

  assign status.irq    = (pending_source != iapg_pkg::SRC_NONE);
  assign status.strobe = strobe_reg;

endmodule

[src/interrupt_aggregator_panel_glue.sv]
`timescale 1ns / 1ps
// channel   | signals                           | payload
// ----------+-----------------------------------+-------------------
// item      | item_valid / item_stall / item     | iapg_pkg::item_t
// result    | result_valid / result_stall / result | iapg_pkg::result_t
//
// One word in, one word out. Two register stages: an input register, then the
// state update and the result register. One word per cycle while result_stall is low.
// rst (synchronous) clears all interrupt, strobe, PCM and dial state.
// result_stall holds both stages; item_stall rises only when both are full.

`include "interrupt_aggregator_panel_glue_macros.svh"

module interrupt_aggregator_panel_glue (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  iapg_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output iapg_pkg::result_t result
);

  logic              s1_valid;
  iapg_pkg::item_t   s1_item;
  logic              s2_load;
  logic              s1_load;
  logic              fire;
  iapg_pkg::result_t core_res;
  iapg_pkg::status_t status;

  assign s2_load    = !result_valid || !result_stall;
  assign s1_load    = !s1_valid || s2_load;
  assign fire       = s1_valid && s2_load;
  assign item_stall = !s1_load;

  iapg_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (s1_item),
    .res    (core_res),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && item_valid) begin
      s1_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_load) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= core_res;
    end
  end

  `IAPG_ASSERT_IMPL(a_stall_only_when_full, item_stall, s1_valid && result_valid && result_stall, "input stalled with room in the pipeline")
  `IAPG_ASSERT_NEXT(a_result_tracks_state, fire, (result.irq_asserted == status.irq) && (result.panel_strobe == status.strobe), "result word disagrees with stored state")
  `IAPG_ASSERT_NEXT(a_irq_read_clears, fire && (s1_item.opcode == iapg_pkg::OP_BUS_READ) && (s1_item.reg_offset == iapg_pkg::REG_IRQ), !status.irq, "interrupt still pending after source read")
  `IAPG_ASSERT_NEXT(a_port_all_masked, fire && (s1_item.opcode == iapg_pkg::OP_PORT) && (status.strobe[4:2] == 3'b111), result.read_data == iapg_pkg::PORT_IDLE, "port read with all rows masked not 0xff")

endmodule
